// ===== rtl/core/swm_pkg.sv =====
// shared constants for the star wildcard matcher
package swm_pkg;

  // pattern byte that matches any run of subject bytes
  localparam logic [7:0] STAR_BYTE = 8'd42;

  // bytes held by the four pattern registers
  localparam int REG_BYTES = 32;

  // default number of pattern positions
  localparam int PATTERN_MAX_DEF = 32;

  // configuration port widths and pattern register count
  localparam int LEN_W      = 6;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int PAT_REGS   = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_LOW      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_SECOND   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_THIRD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_HIGH     = 3'd4;

  // input action codes
  localparam logic ACTION_BYTE = 1'b0;
  localparam logic ACTION_END  = 1'b1;

endpackage

// ===== rtl/core/swm_nfa_step.sv =====
// star closure and one-byte advance of the active position vector
module swm_nfa_step #(
  parameter int PATTERN_MAX = swm_pkg::PATTERN_MAX_DEF,
  parameter int IDX_W       = $clog2(PATTERN_MAX + 1)
) (
  input  logic [PATTERN_MAX:0]          act_i,
  input  logic [PATTERN_MAX-1:0][7:0]   pat_i,
  input  logic [IDX_W-1:0]              len_i,
  input  logic [7:0]                    subj_i,
  output logic [PATTERN_MAX:0]          nxt_o,
  output logic                          hit_o
);
  import swm_pkg::*;

  localparam int LV = $clog2(PATTERN_MAX + 1);

  logic [PATTERN_MAX-1:0] in_len;
  logic [PATTERN_MAX-1:0] is_star;
  logic [PATTERN_MAX:0]   closed;

  // per-position decode: inside the pattern, and star or not
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      in_len[i]  = len_i > IDX_W'(i);
      is_star[i] = pat_i[i] == STAR_BYTE;
    end
  end

  // prefix-or across star runs: position j is reached from j-1 when
  // pattern byte j-1 is an in-range star
  always_comb begin
    logic [PATTERN_MAX:0] g_lv [LV+1];
    logic [PATTERN_MAX:0] p_lv [LV+1];
    g_lv[0] = act_i;
    p_lv[0] = '0;
    for (int j = 1; j <= PATTERN_MAX; j++) begin
      p_lv[0][j] = is_star[j-1] & in_len[j-1];
    end
    for (int l = 0; l < LV; l++) begin
      for (int j = 0; j <= PATTERN_MAX; j++) begin
        if (j >= (1 << l)) begin
          g_lv[l+1][j] = g_lv[l][j] | (p_lv[l][j] & g_lv[l][j - (1 << l)]);
          p_lv[l+1][j] = p_lv[l][j] & p_lv[l][j - (1 << l)];
        end else begin
          g_lv[l+1][j] = g_lv[l][j];
          p_lv[l+1][j] = 1'b0;
        end
      end
    end
    closed = g_lv[LV];
  end

  // advance on the subject byte: stars hold, literals step forward
  always_comb begin
    nxt_o = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (closed[i] && in_len[i]) begin
        if (is_star[i]) begin
          nxt_o[i] = 1'b1;
        end else if (pat_i[i] == subj_i) begin
          nxt_o[i+1] = 1'b1;
        end
      end
    end
  end

  // whole pattern consumed
  assign hit_o = closed[len_i];

endmodule

// ===== rtl/core/star_wildcard_matcher.sv =====
// top level: streamed glob match with '*' as the only wildcard
//
//   port group | direction | handshake        | payload
//   in_        | input     | in_valid/ready   | in_action, in_subject_byte
//   out_       | output    | out_valid/ready  | out_matched
//   cfg_       | input     | cfg_we           | cfg_index, cfg_data
//
// one word per cycle unless an end word stalls: a word is held in the input
// register, then the star closure and byte compare update the active vector.
// an end word loads the result register from the input register.
// reset is synchronous; it rearms position zero and clears the pattern.
// an end word waits in the input register while an untaken result sits, and
// the words behind it wait with it; otherwise nothing stalls.
module star_wildcard_matcher #(
  parameter int PATTERN_MAX = swm_pkg::PATTERN_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_action,
  input  logic [7:0]                      in_subject_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_matched,
  input  logic                            cfg_we,
  input  logic [swm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [swm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import swm_pkg::*;

  localparam int IDX_W = $clog2(PATTERN_MAX + 1);
  localparam logic [PATTERN_MAX:0] ACT_RESET = (PATTERN_MAX + 1)'(1);

  logic [LEN_W-1:0]                    len_r;
  logic [PAT_REGS-1:0][CFG_DATA_W-1:0] pat_r;
  logic [PATTERN_MAX:0]                act_r;
  logic [PATTERN_MAX:0]                act_nxt;
  logic                                s1_valid_r;
  logic                                s1_valid_nxt;
  logic                                s1_action_r;
  logic [7:0]                          s1_byte_r;
  logic                                out_valid_r;
  logic                                out_valid_nxt;
  logic                                out_matched_r;
  logic                                s1_adv;
  logic [IDX_W-1:0]                    len_cl;
  logic [PAT_REGS*CFG_DATA_W-1:0]      pat_flat;
  logic [PATTERN_MAX-1:0][7:0]         pat_bytes;
  logic [PATTERN_MAX:0]                step_nxt;
  logic                                step_hit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      pat_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_LENGTH: len_r    <= cfg_data[LEN_W-1:0];
        REG_BYTES_LOW:      pat_r[0] <= cfg_data;
        REG_BYTES_SECOND:   pat_r[1] <= cfg_data;
        REG_BYTES_THIRD:    pat_r[2] <= cfg_data;
        REG_BYTES_HIGH:     pat_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp the length to the number of positions
  always_comb begin
    if (int'(len_r) > PATTERN_MAX) begin
      len_cl = IDX_W'(PATTERN_MAX);
    end else begin
      len_cl = IDX_W'(len_r);
    end
  end

  // pattern byte per position; positions past the registers read as zero
  assign pat_flat = pat_r;
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (i < REG_BYTES) begin
        pat_bytes[i] = pat_flat[(i % REG_BYTES)*8 +: 8];
      end else begin
        pat_bytes[i] = '0;
      end
    end
  end

  swm_nfa_step #(
    .PATTERN_MAX (PATTERN_MAX),
    .IDX_W       (IDX_W)
  ) u_step (
    .act_i  (act_r),
    .pat_i  (pat_bytes),
    .len_i  (len_cl),
    .subj_i (s1_byte_r),
    .nxt_o  (step_nxt),
    .hit_o  (step_hit)
  );

  // handshake: an end word needs a free result slot
  assign s1_adv   = s1_valid_r && (s1_action_r == ACTION_BYTE || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // active vector update
  always_comb begin
    act_nxt = act_r;
    if (s1_adv) begin
      if (s1_action_r == ACTION_END) begin
        act_nxt = ACT_RESET;
      end else begin
        act_nxt = step_nxt;
      end
    end
  end

  // result slot
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_action_r == ACTION_END) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      act_r       <= ACT_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      act_r       <= act_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action_r <= in_action;
      s1_byte_r   <= in_subject_byte;
    end
    if (s1_adv && s1_action_r == ACTION_END) begin
      out_matched_r <= step_hit;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

`ifndef SYNTH
  // reset leaves only position zero active and nothing in flight
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (act_r == ACT_RESET && !s1_valid_r && !out_valid_r))
    else $error("reset state wrong");

  // an end word rearms the vector
  a_end_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_action_r == ACTION_END) |=> act_r == ACT_RESET)
    else $error("vector not rearmed after end word");

  // a new result only comes from an end word leaving the input register
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || out_ready) ##1 out_valid_r |->
      $past(s1_valid_r && s1_action_r == ACTION_END))
    else $error("result without end word");

  // a byte step never leaves positions past the pattern length active
  a_no_stray_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_action_r == ACTION_BYTE) |=>
      (act_r >> len_cl) <= (PATTERN_MAX + 1)'(1))
    else $error("active bit past pattern length");
`endif

endmodule

// ===== bench/tb_top.sv =====
// testbench for the star wildcard matcher: random and directed subjects
`timescale 1ns / 1ps

import swm_pkg::*;

// predicts the match flag of each end word and checks the result words
class match_scoreboard;
  bit [LEN_W-1:0]        length_reg;
  bit [CFG_DATA_W-1:0]   pattern_regs [PAT_REGS];
  bit [PATTERN_MAX_DEF:0] live_positions;
  bit                    expected_matches [$];
  int unsigned           failures;

  function new();
    length_reg = '0;
    foreach (pattern_regs[i]) pattern_regs[i] = '0;
    live_positions = (PATTERN_MAX_DEF + 1)'(1);
    failures = 0;
  endfunction

  // mirror a register write
  function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
    case (idx)
      REG_PATTERN_LENGTH: length_reg = data[LEN_W-1:0];
      REG_BYTES_LOW:      pattern_regs[0] = data;
      REG_BYTES_SECOND:   pattern_regs[1] = data;
      REG_BYTES_THIRD:    pattern_regs[2] = data;
      REG_BYTES_HIGH:     pattern_regs[3] = data;
      default: ;
    endcase
  endfunction

  function bit [7:0] pattern_byte(int unsigned pos);
    if (pos >= REG_BYTES) return 8'h00;
    return pattern_regs[pos / 8][(pos % 8) * 8 +: 8];
  endfunction

  // advance the active positions by one accepted input word
  function void accept_word(bit action, bit [7:0] subject_byte);
    int unsigned n;
    bit [7:0] pat;
    bit [PATTERN_MAX_DEF:0] next_positions;
    n = (length_reg > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : length_reg;
    // a live star also makes the following position live
    for (int unsigned i = 0; i < n; i++) begin
      if (live_positions[i] && pattern_byte(i) == STAR_BYTE) live_positions[i + 1] = 1'b1;
    end
    // end of subject: report and rearm
    if (action == ACTION_END) begin
      expected_matches = {expected_matches, live_positions[n]};
      live_positions = (PATTERN_MAX_DEF + 1)'(1);
      return;
    end
    next_positions = '0;
    for (int unsigned i = 0; i < n; i++) begin
      if (live_positions[i]) begin
        pat = pattern_byte(i);
        if (pat == STAR_BYTE) next_positions[i] = 1'b1;
        else if (pat == subject_byte) next_positions[i + 1] = 1'b1;
      end
    end
    live_positions = next_positions;
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    failures++;
  endtask

  // compare one result word with the oldest expected flag
  task check_match(logic matched);
    bit want;
    if (expected_matches.size() == 0) begin
      report($sformatf("result word matched=%0b with nothing expected", matched));
      return;
    end
    want = expected_matches.pop_front();
    if (matched !== want) report($sformatf("matched got %0b want %0b", matched, want));
  endtask
endclass

module tb_top;

  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned STALL_LIMIT  = 2000;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic                   in_action;
  logic [7:0]             in_subject_byte;
  logic                   out_valid;
  logic                   out_ready;
  logic                   out_matched;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  match_scoreboard sb = new();

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned words_sent;
  int unsigned stall_cycles;
  int unsigned gen_len;
  bit [7:0]    pat_buf [REG_BYTES];

  star_wildcard_matcher DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_subject_byte (in_subject_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_matched     (out_matched),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stalls, check every accepted word
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_match(out_matched);
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // push one word, idling at random before it
  task send_word(bit action, bit [7:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= action;
    in_subject_byte <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.accept_word(action, value);
    words_sent++;
  endtask

  // stop sending and let every result and in-flight byte word retire
  task wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write the length register and the four byte registers from pat_buf
  task load_pattern(bit [LEN_W-1:0] len_val);
    bit [CFG_DATA_W-1:0] data;
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_PATTERN_LENGTH;
    cfg_data  <= CFG_DATA_W'(len_val);
    @(posedge clk);
    sb.write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len_val));
    for (int r = 0; r < PAT_REGS; r++) begin
      for (int b = 0; b < 8; b++) data[b * 8 +: 8] = pat_buf[r * 8 + b];
      cfg_index <= REG_BYTES_LOW + r[CFG_IDX_W-1:0];
      cfg_data  <= data;
      @(posedge clk);
      sb.write_reg(REG_BYTES_LOW + r[CFG_IDX_W-1:0], data);
    end
    cfg_we <= 1'b0;
  endtask

  // pattern from a string, unused bytes random
  task set_pattern(string s, bit [LEN_W-1:0] len_val);
    foreach (pat_buf[i]) pat_buf[i] = (i < s.len()) ? s[i] : 8'($urandom_range(255));
    load_pattern(len_val);
  endtask

  task send_subject(string s);
    for (int i = 0; i < s.len(); i++) send_word(ACTION_BYTE, s[i]);
    send_word(ACTION_END, 8'($urandom_range(255)));
  endtask

  function automatic bit [7:0] pattern_char();
    case ($urandom_range(9))
      0, 1, 2: return STAR_BYTE;
      3, 4:    return "a";
      5, 6:    return "b";
      7:       return "c";
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic bit [7:0] subject_char();
    case ($urandom_range(9))
      0, 1, 2, 3: return "a";
      4, 5:       return "b";
      6:          return "c";
      7:          return STAR_BYTE;
      default:    return 8'($urandom_range(255));
    endcase
  endfunction

  // random pattern, mostly short, with empty, full and oversized lengths
  task random_pattern();
    int unsigned n;
    case ($urandom_range(19))
      0:       n = 0;
      1:       n = REG_BYTES;
      2:       n = $urandom_range(REG_BYTES + 1, 63);
      default: n = $urandom_range(1, 8);
    endcase
    gen_len = (n > REG_BYTES) ? REG_BYTES : n;
    foreach (pat_buf[i]) pat_buf[i] = (i < gen_len) ? pattern_char() : 8'($urandom_range(255));
    load_pattern(n[LEN_W-1:0]);
  endtask

  // subject built along the pattern with a few faults, or plain noise
  task send_random_subject();
    if ($urandom_range(99) < 75) begin
      for (int unsigned i = 0; i < gen_len; i++) begin
        if (pat_buf[i] == STAR_BYTE) begin
          repeat ($urandom_range(0, 3)) send_word(ACTION_BYTE, subject_char());
        end else if ($urandom_range(99) < 5) begin
          send_word(ACTION_BYTE, subject_char());
        end else begin
          send_word(ACTION_BYTE, pat_buf[i]);
        end
      end
      if ($urandom_range(99) < 10) send_word(ACTION_BYTE, subject_char());
    end else begin
      repeat ($urandom_range(0, 6)) send_word(ACTION_BYTE, subject_char());
    end
    send_word(ACTION_END, 8'($urandom_range(255)));
  endtask

  // main sequence
  initial begin
    int unsigned phase_goal;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_action       <= ACTION_BYTE;
    in_subject_byte <= 8'h00;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_PATTERN_LENGTH;
    cfg_data        <= '0;
    send_idle_pct = 31;
    recv_idle_pct = 70;
    words_sent    = 0;
    gen_len       = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // empty pattern after reset: only the empty subject matches
    send_word(ACTION_END, 8'hFF);
    send_word(ACTION_BYTE, 8'h00);
    send_word(ACTION_END, 8'h00);

    // full length of stars matches anything
    foreach (pat_buf[i]) pat_buf[i] = STAR_BYTE;
    load_pattern(LEN_W'(REG_BYTES));
    send_word(ACTION_BYTE, 8'hFF);
    send_word(ACTION_BYTE, 8'h00);
    send_word(ACTION_END, 8'h00);
    send_word(ACTION_END, 8'hFF);

    // oversized length clamps to the full pattern: stars then a literal
    foreach (pat_buf[i]) pat_buf[i] = STAR_BYTE;
    pat_buf[REG_BYTES - 1] = "z";
    load_pattern(6'd63);
    send_subject("z");
    send_subject("");

    // literal, star, literal
    set_pattern("a*b", 6'd3);
    send_subject("ab");
    send_subject("ac");

    // all-ones pattern bytes
    foreach (pat_buf[i]) pat_buf[i] = 8'hFF;
    load_pattern(6'd2);
    send_word(ACTION_BYTE, 8'hFF);
    send_word(ACTION_BYTE, 8'hFF);
    send_word(ACTION_END, 8'h00);

    // new length between two words of one subject keeps the live positions
    set_pattern("a*b", 6'd3);
    send_word(ACTION_BYTE, "a");
    load_pattern(6'd1);
    send_word(ACTION_END, 8'h00);

    // random part in three idling phases
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_goal = words_sent + 640;
      while (words_sent < phase_goal) begin
        random_pattern();
        repeat ($urandom_range(3, 10)) send_random_subject();
      end
    end

    // wind down
    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.expected_matches.size() != 0) begin
      sb.report($sformatf("%0d match words never arrived", sb.expected_matches.size()));
    end
    if (sb.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/swm_pkg.sv
rtl/core/swm_nfa_step.sv
rtl/core/star_wildcard_matcher.sv
bench/tb_top.sv
